### src/cswp_pkg.sv
// ----------------------------------------------------------------------------
// cswp_pkg
// Shared types and constants for the comment stripper with position tracking.
// ----------------------------------------------------------------------------
package cswp_pkg;

	localparam logic [7:0] COMMENT_CHAR_RESET = 8'd35;
	localparam logic [7:0] NEWLINE_BYTE       = 8'd10;
	localparam logic [7:0] PRINT_LOW          = 8'h20;
	localparam logic [7:0] PRINT_HIGH         = 8'h7E;
	localparam int unsigned ERR_POS_WIDTH     = 16;

	// One source byte as it enters the core
	typedef struct packed {
		logic [7:0] in_char;
		logic       is_last;
	} item_t;

	// One result of the core
	typedef struct packed {
		logic [7:0]               out_char;
		logic                     out_valid;
		logic                     done_res;
		logic                     unclosed_block;
		logic [ERR_POS_WIDTH-1:0] error_line;
		logic [ERR_POS_WIDTH-1:0] error_col;
	} result_t;

endpackage

### src/comment_stripper_with_position_top.sv
// ----------------------------------------------------------------------------
// comment_stripper_with_position_top
// Streams source bytes and strips comments, reporting block comment position.
// ----------------------------------------------------------------------------
// Every input byte gives exactly one result, one byte per cycle sustained
// unless the output stalls: a byte is registered at the input, the comment
// and position logic reads it, and the result lands in an output register;
// a full output register does not stop the input while the result is being
// taken. The result's tuser bit says whether tdata carries a byte of the
// stripped text; tlast marks the result for the final byte, which also
// reports an unclosed block comment and the position of the last block toggle.
// The comment character register may only be written while no byte is in
// flight. After the final byte all tracking state returns to its reset value.
module comment_stripper_with_position_top #(
	parameter int unsigned POSITION_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,      // comment_char
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
	input  logic        s_axis_tlast,   // is_last
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [7:0] out_char, [8] unclosed_block,
	                                    // [24:9] error_line, [40:25] error_col,
	                                    // [47:41] zero
	output logic        m_axis_tlast,   // done_res
	output logic        m_axis_tuser    // out_valid
);

	logic [7:0]         comment_char_q;
	logic               valid_s1;
	cswp_pkg::item_t    item_s1;
	logic               valid_s2;
	cswp_pkg::result_t  res_s2;
	cswp_pkg::result_t  res_c;
	logic               advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_char_q <= cswp_pkg::COMMENT_CHAR_RESET;
		end else if (cfg_we) begin
			comment_char_q <= cfg_wdata;
		end
	end

	// Output stage advances when empty or when the result is taken
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.in_char <= s_axis_tdata;
			item_s1.is_last <= s_axis_tlast;
		end
	end

	cswp_core #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (valid_s1 && advance),
		.item         (item_s1),
		.comment_char (comment_char_q),
		.result       (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, res_s2.error_col, res_s2.error_line,
	                        res_s2.unclosed_block, res_s2.out_char};
	assign m_axis_tlast  = res_s2.done_res;
	assign m_axis_tuser  = res_s2.out_valid;

endmodule

### src/cswp_core.sv
// ----------------------------------------------------------------------------
// cswp_core
// Comment state, line/column tracking and result forming for one byte per
// cycle. State advances only when step is high.
// ----------------------------------------------------------------------------
module cswp_core #(
	parameter int unsigned POSITION_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  cswp_pkg::item_t     item,
	input  logic [7:0]          comment_char,
	output cswp_pkg::result_t   result
);

	localparam int unsigned PW = POSITION_WIDTH;
	localparam int unsigned EW = cswp_pkg::ERR_POS_WIDTH;

	logic          in_line_q, in_block_q, pend_q, prev_pr_q, started_q;
	logic [PW-1:0] line_q, col_q, mline_q, mcol_q, bline_q, bcol_q;

	logic          in_line_d, in_block_d, pend_d;
	logic [PW-1:0] line_d, col_d, mline_d, mcol_d, bline_d, bcol_d;
	logic          is_nl, is_cc, valid;
	logic [PW-1:0] col_inc;

	// Classify the byte
	assign is_nl = (item.in_char == cswp_pkg::NEWLINE_BYTE);
	assign is_cc = (item.in_char == comment_char);

	// Track position: column counts after a printable byte, newline wraps
	always_comb begin
		col_inc = (prev_pr_q && (col_q != '1)) ? col_q + 1'b1 : col_q;
		line_d  = line_q;
		col_d   = col_q;
		if (started_q) begin
			col_d = col_inc;
			if (is_nl) begin
				line_d = (line_q != '1) ? line_q + 1'b1 : line_q;
				col_d  = '0;
			end
		end
	end

	// Comment mode transitions
	always_comb begin
		in_line_d  = in_line_q;
		in_block_d = in_block_q;
		pend_d     = pend_q;
		mline_d    = mline_q;
		mcol_d     = mcol_q;
		bline_d    = bline_q;
		bcol_d     = bcol_q;
		valid      = 1'b0;
		if (pend_q) begin
			pend_d = 1'b0;
			if (is_cc) begin
				in_block_d = !in_block_q;
				bline_d    = mline_q;
				bcol_d     = mcol_q;
			end else if (is_nl) begin
				valid = 1'b1;
			end else begin
				in_line_d = 1'b1;
			end
		end else if (in_line_q) begin
			if (is_nl) begin
				in_line_d = 1'b0;
				valid     = 1'b1;
			end
		end else if (is_cc) begin
			if (item.is_last) begin
				in_line_d = 1'b1;
			end else begin
				pend_d  = 1'b1;
				mline_d = line_d;
				mcol_d  = col_d;
			end
		end else if (!in_block_q || is_nl) begin
			valid = 1'b1;
		end
	end

	// Form the result; error position saturates to the reported width when wider, else zero-extends
	generate
		if (PW > EW) begin : g_sat
			assign result.error_line = (|bline_d[PW-1:EW]) ? {EW{1'b1}} : bline_d[EW-1:0];
			assign result.error_col  = (|bcol_d[PW-1:EW])  ? {EW{1'b1}} : bcol_d[EW-1:0];
		end else if (PW == EW) begin : g_same
			assign result.error_line = bline_d;
			assign result.error_col  = bcol_d;
		end else begin : g_ext
			assign result.error_line = {{(EW-PW){1'b0}}, bline_d};
			assign result.error_col  = {{(EW-PW){1'b0}}, bcol_d};
		end
	endgenerate

	assign result.out_char       = valid ? item.in_char : 8'd0;
	assign result.out_valid      = valid;
	assign result.done_res       = item.is_last;
	assign result.unclosed_block = item.is_last && in_block_d;

	// Hold state; clear everything after the final byte of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q  <= 1'b0;
			in_block_q <= 1'b0;
			pend_q     <= 1'b0;
			prev_pr_q  <= 1'b0;
			started_q  <= 1'b0;
			line_q     <= '0;
			col_q      <= '0;
			mline_q    <= '0;
			mcol_q     <= '0;
			bline_q    <= '1;
			bcol_q     <= '1;
		end else if (step) begin
			if (item.is_last) begin
				in_line_q  <= 1'b0;
				in_block_q <= 1'b0;
				pend_q     <= 1'b0;
				prev_pr_q  <= 1'b0;
				started_q  <= 1'b0;
				line_q     <= '0;
				col_q      <= '0;
				mline_q    <= '0;
				mcol_q     <= '0;
				bline_q    <= '1;
				bcol_q     <= '1;
			end else begin
				in_line_q  <= in_line_d;
				in_block_q <= in_block_d;
				pend_q     <= pend_d;
				prev_pr_q  <= (item.in_char >= cswp_pkg::PRINT_LOW) &&
				              (item.in_char <= cswp_pkg::PRINT_HIGH);
				started_q  <= 1'b1;
				line_q     <= line_d;
				col_q      <= col_d;
				mline_q    <= mline_d;
				mcol_q     <= mcol_d;
				bline_q    <= bline_d;
				bcol_q     <= bcol_d;
			end
		end
	end

endmodule
